>>> design/tpra_pkg.sv
// Shared types, formats and arctangent constants for the two-point rotation angle block.
`default_nettype none
package tpra_pkg;

   // CORDIC datapath width: scaled differences take 59 bits, plus growth headroom.
   localparam int CordicWidth = 62;
   localparam int AccWidth    = 32;
   localparam int MaxSteps    = 32;

   typedef struct packed {
      logic        contact_one_down;
      logic        contact_two_down;
      logic [15:0] point_one_x;
      logic [15:0] point_one_y;
      logic [15:0] point_two_x;
      logic [15:0] point_two_y;
   } tpra_req_type;

   typedef struct packed {
      logic        rotate_active;
      logic        angle_updated;
      logic [15:0] rotate_angle;
   } tpra_rsp_type;

   typedef struct packed {
      logic                          zero;
      logic signed [CordicWidth-1:0] x;
      logic signed [CordicWidth-1:0] y;
      logic [AccWidth-1:0]           acc;
   } tpra_cordic_type;

   // atan(2^-i) with 2^32 units per turn, rounded to nearest.
   function automatic logic [AccWidth-1:0] atan_unit(input logic [4:0] idx);
      logic [AccWidth-1:0] val;
      unique case (idx)
         5'd0:  val = 32'h20000000;
         5'd1:  val = 32'h12E4051E;
         5'd2:  val = 32'h09FB385B;
         5'd3:  val = 32'h051111D4;
         5'd4:  val = 32'h028B0D43;
         5'd5:  val = 32'h0145D7E1;
         5'd6:  val = 32'h00A2F61E;
         5'd7:  val = 32'h00517C55;
         5'd8:  val = 32'h0028BE53;
         5'd9:  val = 32'h00145F2F;
         5'd10: val = 32'h000A2F98;
         5'd11: val = 32'h000517CC;
         5'd12: val = 32'h00028BE6;
         5'd13: val = 32'h000145F3;
         5'd14: val = 32'h0000A2FA;
         5'd15: val = 32'h0000517D;
         5'd16: val = 32'h000028BE;
         5'd17: val = 32'h0000145F;
         5'd18: val = 32'h00000A30;
         5'd19: val = 32'h00000518;
         5'd20: val = 32'h0000028C;
         5'd21: val = 32'h00000146;
         5'd22: val = 32'h000000A3;
         5'd23: val = 32'h00000051;
         5'd24: val = 32'h00000029;
         5'd25: val = 32'h00000014;
         5'd26: val = 32'h0000000A;
         5'd27: val = 32'h00000005;
         5'd28: val = 32'h00000003;
         5'd29: val = 32'h00000001;
         5'd30: val = 32'h00000001;
         5'd31: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

>>> design/tpra_cell.sv
// One CORDIC vectoring iteration with its output register.
`default_nettype none
module tpra_cell #(
   parameter int IDX = 0
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire tpra_pkg::tpra_cordic_type in_data,
   output logic                           out_valid,
   output tpra_pkg::tpra_cordic_type      out_data
);
   import tpra_pkg::*;

   logic                          valid_ff;
   tpra_cordic_type               data_ff;
   tpra_cordic_type               data_in;
   logic signed [CordicWidth-1:0] sx;
   logic signed [CordicWidth-1:0] sy;
   logic [AccWidth-1:0]           step_angle;

   assign sx         = in_data.x >>> IDX;
   assign sy         = in_data.y >>> IDX;
   assign step_angle = atan_unit(5'(IDX));

   always_comb begin
      data_in      = in_data;
      if (in_data.y > 0) begin
         data_in.x   = in_data.x + sy;
         data_in.y   = in_data.y - sx;
         data_in.acc = in_data.acc + step_angle;
      end else begin
         data_in.x   = in_data.x - sy;
         data_in.y   = in_data.y + sx;
         data_in.acc = in_data.acc - step_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

>>> design/two_point_rotation_angle.sv
// Two-point rotation angle: top level with front end, cell chain and gesture state.
//
// Usage: one touch sample is taken per req_ word (valid/ready) and exactly one
// result word is returned per sample on the rsp_ channel (valid/ready).
// A sample with either contact up returns at the next cycle with rotate_active
// and angle_updated low and the held angle repeated. A sample with both
// contacts down enters a row of CORDIC_STEPS iteration cells (capped at 32);
// its result passes the input register and each cell register on its way to
// the output register. The first such sample of a gesture sets the reference
// and reports 0; later ones report the angle relative to it, modulo one turn.
// One sample is in flight at a time: req_ready is low from acceptance until
// the result word is taken, so a new sample is accepted only once the last
// result word has left the output register.
// A stalled receiver simply holds the result word and blocks new samples.
// Reset clears the gesture flag, the reference and the held angle, and
// empties the chain and the output register.
`default_nettype none
module two_point_rotation_angle #(
   parameter int COORD_BITS   = 16,
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire tpra_pkg::tpra_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output tpra_pkg::tpra_rsp_type      rsp_data
);
   import tpra_pkg::*;

   localparam int Steps = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
   localparam int Guard = 58 - COORD_BITS;
   localparam int Shift = AccWidth - ANGLE_BITS;
   localparam logic [58:0] CoordMask = 59'((60'd1 << COORD_BITS) - 60'd1);
   localparam logic [AccWidth:0] RoundHalf = (33'd1 << Shift) >> 1;

   logic                  busy_ff;
   logic                  rotating_ff;
   logic [ANGLE_BITS-1:0] ref_ff;
   logic [ANGLE_BITS-1:0] held_ff;
   logic                  rsp_valid_ff;
   tpra_rsp_type          rsp_data_ff;
   logic                  valid0_ff;
   tpra_cordic_type       data0_ff;
   tpra_cordic_type       data0_in;

   logic                  chain_valid [Steps+1];
   tpra_cordic_type       chain_data  [Steps+1];

   logic                          req_fire;
   logic                          both_down;
   logic [58:0]                   x1_ext, y1_ext, x2_ext, y2_ext;
   logic signed [58:0]            dx, dy;
   logic signed [CordicWidth-1:0] xs, ys;
   logic [AccWidth:0]             round_sum;
   logic [ANGLE_BITS-1:0]         angle_val;
   logic [ANGLE_BITS-1:0]         rel_angle;
   logic [47:0]                   held_wide;

   assign req_fire  = req_valid && req_ready;
   assign both_down = req_data.contact_one_down && req_data.contact_two_down;
   assign req_ready = !busy_ff;

   // front end: coordinate differences, guard scaling, half-plane fold
   always_comb begin
      x1_ext = 59'(req_data.point_one_x) & CoordMask;
      y1_ext = 59'(req_data.point_one_y) & CoordMask;
      x2_ext = 59'(req_data.point_two_x) & CoordMask;
      y2_ext = 59'(req_data.point_two_y) & CoordMask;
      dx     = signed'(x2_ext - x1_ext);
      dy     = signed'(y2_ext - y1_ext);
      xs     = {{3{dx[58]}}, dx} <<< Guard;
      ys     = {{3{dy[58]}}, dy} <<< Guard;
      data0_in.zero = (dx == '0) && (dy == '0);
      if (xs < 0) begin
         data0_in.x   = -xs;
         data0_in.y   = -ys;
         data0_in.acc = 32'h80000000;
      end else begin
         data0_in.x   = xs;
         data0_in.y   = ys;
         data0_in.acc = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         data0_ff <= data0_in;
      end
   end

   assign chain_valid[0] = valid0_ff;
   assign chain_data[0]  = data0_ff;

   for (genvar i = 0; i < Steps; i++) begin : g_cell
      tpra_cell #(
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // back end: round to ANGLE_BITS, relative to reference
   always_comb begin
      round_sum = {1'b0, chain_data[Steps].acc} + RoundHalf;
      angle_val = chain_data[Steps].zero ? '0 : round_sum[AccWidth-1:Shift];
      rel_angle = rotating_ff ? (angle_val - ref_ff) : '0;
   end

   assign held_wide = 48'(held_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         valid0_ff    <= 1'b0;
         rotating_ff  <= 1'b0;
         ref_ff       <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid0_ff <= req_fire && both_down;
         if (req_fire) begin
            busy_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            busy_ff <= 1'b0;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire && !both_down) begin
            rotating_ff                <= 1'b0;
            rsp_valid_ff               <= 1'b1;
            rsp_data_ff.rotate_active  <= 1'b0;
            rsp_data_ff.angle_updated  <= 1'b0;
            rsp_data_ff.rotate_angle   <= held_wide[15:0];
         end
         if (chain_valid[Steps]) begin
            if (!rotating_ff) begin
               ref_ff <= angle_val;
            end
            rotating_ff                <= 1'b1;
            held_ff                    <= rel_angle;
            rsp_valid_ff               <= 1'b1;
            rsp_data_ff.rotate_active  <= 1'b1;
            rsp_data_ff.angle_updated  <= 1'b1;
            rsp_data_ff.rotate_angle   <= 16'(48'(rel_angle));
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_rsp_implies_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> busy_ff)
      else $error("result word pending while block not busy");

   a_chain_into_empty: assert property (@(posedge clock) disable iff (reset)
      chain_valid[Steps] |-> !rsp_valid_ff)
      else $error("chain result arrived while output register full");

   a_contact_up_fast: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !both_down) |=> (rsp_valid_ff && !rsp_data_ff.angle_updated))
      else $error("contact-up sample did not return next cycle");

   a_rsp_drops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready) |=> !rsp_valid_ff)
      else $error("result word repeated after acceptance");
`endif

endmodule
`default_nettype wire

>>> dv/tb_two_point_rotation_angle.sv
// Testbench for two_point_rotation_angle: directed and random touch samples vs a CORDIC predictor.
module tb_two_point_rotation_angle;
   import tpra_pkg::*;

   localparam int GUARD_SHIFT = 42;
   localparam int STEP_COUNT  = 16;
   localparam int STALL_LIMIT = 3000;
   localparam int QUIET_TAIL  = 40;

   // atan(2^-i), 2^32 per turn, entry 0 in the low word
   localparam bit [STEP_COUNT*32-1:0] ATAN_TURN = {
      32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
      32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
      32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
      32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   tpra_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   tpra_rsp_type rsp_data;

   tpra_rsp_type pending_results[$];
   int unsigned  mismatch_count = 0;
   int unsigned  quiet_cycles = 0;
   int unsigned  samples_sent = 0;
   bit           steady_traffic = 1'b0;

   bit           gesture_on = 1'b0;
   bit [15:0]    gesture_ref = '0;
   bit [15:0]    held_angle = '0;

   two_point_rotation_angle DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit [15:0] cordic_heading(input int dx, input int dy);
      longint    x;
      longint    y;
      longint    nx;
      longint    ny;
      bit [31:0] turn;
      bit [32:0] rounded;
      turn = '0;
      if (dx == 0 && dy == 0) begin
         return 16'h0000;
      end
      x = longint'(dx) <<< GUARD_SHIFT;
      y = longint'(dy) <<< GUARD_SHIFT;
      if (x < 0) begin
         x = -x;
         y = -y;
         turn = 32'h80000000;
      end
      for (int i = 0; i < STEP_COUNT; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            turn = turn + ATAN_TURN[i*32 +: 32];
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            turn = turn - ATAN_TURN[i*32 +: 32];
         end
         x = nx;
         y = ny;
      end
      rounded = {1'b0, turn} + 33'h0000_8000;
      return rounded[31:16];
   endfunction

   function automatic tpra_rsp_type predict_rotation(input tpra_req_type s);
      tpra_rsp_type r;
      bit [15:0]    heading;
      r = '0;
      if (!(s.contact_one_down && s.contact_two_down)) begin
         gesture_on = 1'b0;
         r.rotate_angle = held_angle;
         return r;
      end
      heading = cordic_heading(int'(s.point_two_x) - int'(s.point_one_x),
                               int'(s.point_two_y) - int'(s.point_one_y));
      if (!gesture_on) begin
         gesture_on = 1'b1;
         gesture_ref = heading;
         held_angle = '0;
      end else begin
         held_angle = heading - gesture_ref;
      end
      r.rotate_active = 1'b1;
      r.angle_updated = 1'b1;
      r.rotate_angle = held_angle;
      return r;
   endfunction

   function automatic tpra_req_type make_sample(input bit d1, input bit d2,
                                                input bit [15:0] x1, input bit [15:0] y1,
                                                input bit [15:0] x2, input bit [15:0] y2);
      tpra_req_type s;
      s.contact_one_down = d1;
      s.contact_two_down = d2;
      s.point_one_x = x1;
      s.point_one_y = y1;
      s.point_two_x = x2;
      s.point_two_y = y2;
      return s;
   endfunction

   function automatic int pick_offset();
      case ($urandom_range(0, 2))
         0: return int'($urandom_range(0, 8)) - 4;
         1: return int'($urandom_range(0, 600)) - 300;
         default: return int'($urandom_range(0, 131070)) - 65535;
      endcase
   endfunction

   function automatic tpra_req_type lifted_sample();
      bit [1:0] flags;
      flags = 2'($urandom_range(0, 2));
      return make_sample(flags[1], flags[0], 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // one word in; valid stays up across back-to-back words
   task automatic send_sample(input tpra_req_type sample);
      int unsigned gap;
      gap = 0;
      if (!steady_traffic) begin
         while ($urandom_range(0, 99) < 26) gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= sample;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_rotation(sample));
      samples_sent++;
   endtask

   task automatic run_gesture(input int unsigned len);
      bit [15:0] x1;
      bit [15:0] y1;
      repeat ($urandom_range(0, 2)) send_sample(lifted_sample());
      for (int unsigned n = 0; n < len; n++) begin
         if ($urandom_range(0, 14) == 0) begin
            send_sample(lifted_sample());
         end else begin
            x1 = 16'($urandom);
            y1 = 16'($urandom);
            send_sample(make_sample(1'b1, 1'b1, x1, y1,
                                    16'(int'(x1) + pick_offset()),
                                    16'(int'(y1) + pick_offset())));
         end
      end
   endtask

   task automatic test_directed_cases();
      send_sample(make_sample(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_sample(make_sample(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_sample(make_sample(1'b1, 1'b0, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));
      // coincident points open the gesture
      send_sample(make_sample(1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_sample(make_sample(1'b1, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000));
      send_sample(make_sample(1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
      send_sample(make_sample(1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
      send_sample(make_sample(1'b1, 1'b1, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
      send_sample(make_sample(1'b1, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
      send_sample(make_sample(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
      send_sample(make_sample(1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
      send_sample(make_sample(1'b1, 1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000));
      send_sample(make_sample(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_sample(make_sample(1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0001, 16'h0000));
      send_sample(make_sample(1'b1, 1'b1, 16'h0001, 16'h0000, 16'h0000, 16'h0000));
      send_sample(make_sample(1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0001));
      send_sample(make_sample(1'b1, 1'b1, 16'h0005, 16'h0007, 16'h0005, 16'h0006));
      // lift: angle held, then a new reference
      send_sample(make_sample(1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_sample(make_sample(1'b1, 1'b1, 16'h0100, 16'h0100, 16'h0100, 16'h0900));
      send_sample(make_sample(1'b1, 1'b1, 16'h8000, 16'h8000, 16'h7FFF, 16'h8001));
      send_sample(make_sample(1'b1, 1'b1, 16'h4000, 16'hC000, 16'hC000, 16'h4000));
      send_sample(make_sample(1'b1, 1'b0, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
   endtask

   task automatic test_contact_noise();
      repeat (180) begin
         send_sample(make_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom)));
      end
   endtask

   task automatic test_random_gestures(input int unsigned count);
      int unsigned goal;
      goal = samples_sent + count;
      while (samples_sent < goal) run_gesture($urandom_range(1, 30));
   endtask

   task automatic test_steady_stream();
      steady_traffic = 1'b1;
      test_random_gestures(150);
      steady_traffic = 1'b0;
   endtask

   task automatic test_pause_for_drain();
      test_random_gestures(20);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      test_random_gestures(20);
   endtask

   always @(posedge clock) begin
      rsp_ready <= steady_traffic || ($urandom_range(0, 99) >= 26);
   end

   always @(posedge clock) begin
      tpra_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result word with none expected");
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.rotate_active !== want.rotate_active) begin
               report_mismatch($sformatf("rotate_active got %b want %b",
                                         rsp_data.rotate_active, want.rotate_active));
            end
            if (rsp_data.angle_updated !== want.angle_updated) begin
               report_mismatch($sformatf("angle_updated got %b want %b",
                                         rsp_data.angle_updated, want.angle_updated));
            end
            if (rsp_data.rotate_angle !== want.rotate_angle) begin
               report_mismatch($sformatf("rotate_angle got %h want %h",
                                         rsp_data.rotate_angle, want.rotate_angle));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_contact_noise();
      test_random_gestures(400);
      test_pause_for_drain();
      test_steady_stream();
      test_random_gestures(360);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (QUIET_TAIL) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
